// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console cursor engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// check a consequence in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 13;
    localparam int DATA_W = 16;
    localparam int TAB_ENTRIES = 128;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ENQ = 8'h05;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    typedef logic [COL_W:0] tab_table_t [0:TAB_ENTRIES-1];

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
        logic              end_of_string;
    } tcce_item_t;

    typedef struct packed {
        logic              mem_write;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] mem_data;
        logic [ADDR_W-1:0] screen_start;
        logic              scrolled;
        logic              cursor_update;
        logic [ADDR_W-1:0] cursor_position;
    } tcce_result_t;

endpackage

// ===== design/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character stream to text video memory writes with cursor and scroll.
// ----------------------------------------------------------------------------
// The slave channel takes one item per byte: tdata holds char_code and the
// attribute, tlast marks the last byte of a string. The master channel gives
// exactly one item per input item: the video memory write (tuser set when a
// cell is stored), the display start offset, a scroll flag and the cursor
// cell, with tlast asking for a cursor register load.
// Each item passes through the input register and then the result register.
// Throughput is one item per cycle while m_tready is held high; the cursor
// step is a single pass through the row/column logic and two modulo adds on
// the line base. Reset puts the cursor at row 0, column 0 with start offset 0
// and empties both registers. When the receiver stalls, the result register
// holds and the input register takes one more item before s_tready drops.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 8192,
    parameter int TAB_STOP  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcce_pkg::S_TDATA_W-1:0]     s_tdata,   // char_code, attribute
    input  logic                               s_tlast,   // end_of_string
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // mem_address, mem_data, screen_start, scrolled, cursor_position
    output logic [tcce_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,   // mem_write
    output logic                               m_tlast    // cursor_update
);

    logic                   in_valid_reg;
    tcce_pkg::tcce_item_t   in_item_reg;
    logic                   out_valid_reg;
    tcce_pkg::tcce_result_t out_result_reg;
    tcce_pkg::tcce_result_t step_result;
    logic                   step_en;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.char_code     <= s_tdata[7:0];
            in_item_reg.attribute     <= s_tdata[15:8];
            in_item_reg.end_of_string <= s_tlast;
        end
    end

    tcce_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .MEM_CELLS (MEM_CELLS),
        .TAB_STOP  (TAB_STOP)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.mem_write;
    assign m_tlast  = out_result_reg.cursor_update;
    assign m_tdata  = {out_result_reg.cursor_position,
                       out_result_reg.scrolled,
                       out_result_reg.screen_start,
                       out_result_reg.mem_data,
                       out_result_reg.mem_address};

endmodule

// ===== design/tcce_cursor.sv =====
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor state and single-pass next-position logic for one character item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcce_cursor #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 8192,
    parameter int TAB_STOP  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  tcce_pkg::tcce_item_t  item,
    output tcce_pkg::tcce_result_t result
);

    localparam int ADDR_W = tcce_pkg::ADDR_W;
    localparam int COL_W  = tcce_pkg::COL_W;
    localparam int ROW_W  = tcce_pkg::ROW_W;

    localparam logic [ADDR_W:0]  MEM_SIZE  = (ADDR_W+1)'(MEM_CELLS);
    localparam logic [ADDR_W-1:0] ROW_CELLS = ADDR_W'(COLUMNS);
    localparam logic [COL_W:0]   COL_LIMIT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

    function automatic tcce_pkg::tab_table_t build_tab_table();
        tcce_pkg::tab_table_t tbl;
        int stop;
        stop = TAB_STOP;
        for (int i = 0; i < tcce_pkg::TAB_ENTRIES; i++) begin
            if (i >= stop) begin
                stop = stop + TAB_STOP;
            end
            tbl[i] = (COL_W+1)'(stop);
        end
        return tbl;
    endfunction

    localparam tcce_pkg::tab_table_t TAB_NEXT = build_tab_table();

    function automatic logic [ADDR_W-1:0] add_wrap(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= MEM_SIZE) begin
            sum = sum - MEM_SIZE;
        end
        return sum[ADDR_W-1:0];
    endfunction

    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] line_reg,  line_next;

    logic [COL_W:0] col_tmp;
    logic           row_inc;
    logic           wr;
    logic           scroll;

    always_comb begin
        col_tmp = {1'b0, col_reg};
        row_inc = 1'b0;
        wr      = 1'b0;
        case (item.char_code)
            tcce_pkg::CH_NUL, tcce_pkg::CH_ENQ, tcce_pkg::CH_BEL, tcce_pkg::CH_VT,
            tcce_pkg::CH_FF, tcce_pkg::CH_ESC, tcce_pkg::CH_DEL: begin
                col_tmp = {1'b0, col_reg};
            end
            tcce_pkg::CH_BS: begin
                if (col_reg != '0) begin
                    col_tmp = {1'b0, col_reg} - 1'b1;
                end
            end
            tcce_pkg::CH_TAB: begin
                col_tmp = TAB_NEXT[col_reg];
            end
            tcce_pkg::CH_LF: begin
                row_inc = 1'b1;
                col_tmp = '0;
            end
            tcce_pkg::CH_CR: begin
                col_tmp = '0;
            end
            default: begin
                wr      = 1'b1;
                col_tmp = {1'b0, col_reg} + 1'b1;
            end
        endcase

        if (col_tmp >= COL_LIMIT) begin
            col_tmp = '0;
            row_inc = 1'b1;
        end

        scroll     = row_inc && (row_reg == LAST_ROW);
        row_next   = (row_inc && !scroll) ? row_reg + 1'b1 : row_reg;
        col_next   = col_tmp[COL_W-1:0];
        line_next  = row_inc ? add_wrap(line_reg, ROW_CELLS) : line_reg;
        start_next = scroll ? add_wrap(start_reg, ROW_CELLS) : start_reg;

        result.mem_write       = wr;
        result.mem_address     = wr ? add_wrap(line_reg, ADDR_W'(col_reg)) : '0;
        result.mem_data        = wr ? {item.attribute, item.char_code} : '0;
        result.screen_start    = start_next;
        result.scrolled        = scroll;
        result.cursor_update   = item.end_of_string;
        result.cursor_position = add_wrap(line_next, ADDR_W'(col_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            start_reg <= '0;
            line_reg  <= '0;
        end else if (step_en) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            line_reg  <= line_next;
        end
    end

    `ASSERT_ALWAYS(a_col_in_range, aclk, aresetn, col_reg < COL_LIMIT[COL_W-1:0],
        "column past edge")
    `ASSERT_ALWAYS(a_row_in_range, aclk, aresetn, row_reg <= LAST_ROW, "row past last row")
    `ASSERT_NEXT(a_scroll_last_row, aclk, aresetn, step_en && scroll,
        row_reg == LAST_ROW && line_reg == $past(line_next), "scroll left row")
    `ASSERT_NEXT(a_hold_when_idle, aclk, aresetn, !step_en,
        $stable(start_reg) && $stable(line_reg), "state moved without item")

endmodule

// ===== sim/console_write_checker.sv =====
// ----------------------------------------------------------------------------
// console_write_checker
// Watches both channels of the console cursor engine, steps its own copy of
// the cursor, row and screen start for every accepted byte, and compares each
// result item field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module console_write_checker #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 8192,
    parameter int TAB_STOP  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tcce_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tcce_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser,
    input  logic                           m_tlast,
    output int                             errors,
    output int                             outstanding
);

    localparam int ADDR_W = tcce_pkg::ADDR_W;

    int row_now;
    int col_now;
    int start_now;
    tcce_pkg::tcce_result_t writes_due [$];

    function automatic logic [ADDR_W-1:0] cell_at(input int row, input int col);
        return ADDR_W'((start_now + row * COLUMNS + col) % MEM_CELLS);
    endfunction

    function automatic tcce_pkg::tcce_result_t step_cursor(input tcce_pkg::tcce_item_t item);
        tcce_pkg::tcce_result_t res;
        int row;
        int col;
        res = '0;
        row = row_now;
        col = col_now;
        case (item.char_code)
            tcce_pkg::CH_NUL, tcce_pkg::CH_ENQ, tcce_pkg::CH_BEL, tcce_pkg::CH_VT,
            tcce_pkg::CH_FF, tcce_pkg::CH_ESC, tcce_pkg::CH_DEL: ;
            tcce_pkg::CH_BS: begin
                if (col > 0) col--;
            end
            tcce_pkg::CH_TAB: col = (col / TAB_STOP + 1) * TAB_STOP;
            tcce_pkg::CH_LF: begin
                row++;
                col = 0;
            end
            tcce_pkg::CH_CR: col = 0;
            default: begin
                res.mem_write   = 1'b1;
                res.mem_address = cell_at(row, col);
                res.mem_data    = {item.attribute, item.char_code};
                col++;
            end
        endcase
        if (col >= COLUMNS) begin
            col = 0;
            row++;
        end
        if (row >= ROWS) begin
            row          = ROWS - 1;
            start_now    = (start_now + COLUMNS) % MEM_CELLS;
            res.scrolled = 1'b1;
        end
        row_now = row;
        col_now = col;
        res.screen_start    = ADDR_W'(start_now);
        res.cursor_update   = item.end_of_string;
        res.cursor_position = cell_at(row, col);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tcce_pkg::tcce_item_t   item;
        tcce_pkg::tcce_result_t got;
        tcce_pkg::tcce_result_t want;
        if (!aresetn) begin
            row_now   = 0;
            col_now   = 0;
            start_now = 0;
            errors    = 0;
            writes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.mem_write       = m_tuser;
                got.mem_address     = m_tdata[12:0];
                got.mem_data        = m_tdata[28:13];
                got.screen_start    = m_tdata[41:29];
                got.scrolled        = m_tdata[42];
                got.cursor_update   = m_tlast;
                got.cursor_position = m_tdata[55:43];
                if (writes_due.size() == 0) begin
                    errors++;
                    $display("%0t: result item expected none actual %0h", $time, got);
                end else begin
                    want = writes_due.pop_front();
                    check_field("mem_write", int'(want.mem_write), int'(got.mem_write));
                    check_field("mem_address", int'(want.mem_address),
                                int'(got.mem_address));
                    check_field("mem_data", int'(want.mem_data), int'(got.mem_data));
                    check_field("screen_start", int'(want.screen_start),
                                int'(got.screen_start));
                    check_field("scrolled", int'(want.scrolled), int'(got.scrolled));
                    check_field("cursor_update", int'(want.cursor_update),
                                int'(got.cursor_update));
                    check_field("cursor_position", int'(want.cursor_position),
                                int'(got.cursor_position));
                end
            end
            if (s_tvalid && s_tready) begin
                item.char_code     = s_tdata[7:0];
                item.attribute     = s_tdata[15:8];
                item.end_of_string = s_tlast;
                writes_due.push_back(step_cursor(item));
            end
        end
        outstanding = writes_due.size();
    end

endmodule

// ===== sim/tb_text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine
// Feeds the console cursor engine a directed run of control bytes and edge
// values, then random text lines, line feed bursts and noise with random
// idling on both channels; the checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine;

    localparam int STALL_LIMIT  = 2000;
    localparam int TOTAL_ITEMS  = 1250;
    localparam int QUIET_FROM   = 1100;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tcce_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tcce_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    int errors;
    int outstanding;
    int quiet_cycles;
    int rx_hold;
    int sent;
    bit idle_on;

    logic [tcce_pkg::CHAR_W-1:0] ctrl_codes [11] = '{
        tcce_pkg::CH_NUL, tcce_pkg::CH_ENQ, tcce_pkg::CH_BEL, tcce_pkg::CH_BS,
        tcce_pkg::CH_TAB, tcce_pkg::CH_LF, tcce_pkg::CH_VT, tcce_pkg::CH_FF,
        tcce_pkg::CH_CR, tcce_pkg::CH_ESC, tcce_pkg::CH_DEL};

    text_console_cursor_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    console_write_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_hold  <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] ch, input logic [7:0] attr, input logic eos);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {attr, ch};
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    initial begin
        int kind;
        int n;
        int pick;
        logic [7:0] ch;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        idle_on  = 1'b0;
        sent     = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_byte(tcce_pkg::CH_NUL, 8'h00, 1'b0);
        push_byte(tcce_pkg::CH_ENQ, 8'hFF, 1'b1);
        push_byte(tcce_pkg::CH_BEL, 8'h00, 1'b0);
        push_byte(tcce_pkg::CH_VT, 8'hFF, 1'b1);
        push_byte(tcce_pkg::CH_FF, 8'h00, 1'b0);
        push_byte(tcce_pkg::CH_ESC, 8'hFF, 1'b1);
        push_byte(tcce_pkg::CH_DEL, 8'h00, 1'b0);
        push_byte(tcce_pkg::CH_BS, 8'h07, 1'b1);
        push_byte(8'h41, 8'h00, 1'b0);
        push_byte(8'hFF, 8'hFF, 1'b1);
        push_byte(8'h80, 8'h55, 1'b0);
        push_byte(8'h01, 8'hAA, 1'b0);
        push_byte(8'h7E, 8'h07, 1'b0);
        push_byte(8'h20, 8'h07, 1'b1);
        push_byte(tcce_pkg::CH_BS, 8'h07, 1'b0);
        push_byte(tcce_pkg::CH_TAB, 8'h07, 1'b0);
        push_byte(tcce_pkg::CH_CR, 8'h07, 1'b1);
        // run tabs off the right edge
        repeat (10) push_byte(tcce_pkg::CH_TAB, 8'h07, 1'b0);
        push_byte(tcce_pkg::CH_LF, 8'h07, 1'b1);
        push_byte(tcce_pkg::CH_CR, 8'h07, 1'b0);

        while (sent < TOTAL_ITEMS) begin
            idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170)
                                                : $urandom_range(0, 24);
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0) ch = tcce_pkg::CH_TAB;
                    else if (pick == 1) ch = tcce_pkg::CH_BS;
                    else if (pick < 5) ch = 8'($urandom_range(8'h80, 8'hFF));
                    else ch = 8'($urandom_range(8'h20, 8'h7E));
                    push_byte(ch, 8'($urandom_range(0, 255)), 1'b0);
                end
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(tcce_pkg::CH_CR, 8'($urandom_range(0, 255)), 1'b0);
                end
                push_byte(($urandom_range(0, 3) == 0) ? tcce_pkg::CH_CR : tcce_pkg::CH_LF,
                          8'($urandom_range(0, 255)), 1'b1);
            end else if (kind < 15) begin
                n = $urandom_range(1, 30);
                repeat (n) push_byte(tcce_pkg::CH_LF, 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0) ch = ctrl_codes[$urandom_range(0, 10)];
                    else ch = 8'($urandom_range(0, 255));
                    push_byte(ch, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/tcce_pkg.sv
design/tcce_cursor.sv
design/text_console_cursor_engine.sv
sim/console_write_checker.sv
sim/tb_text_console_cursor_engine.sv
